// File: hdl/lprl_pkg.sv
// Shared types and constants for the longest-prefix route lookup block.
// Used by the table, the scan engine and the top level; depends on nothing.
`default_nettype none

package lprl_pkg;

  localparam int ENTRIES = 16;
  localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IDX_W   = 4;
  localparam int PORT_W  = 4;
  localparam int ADDR_W  = 32;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } eng_state_e;

  // One table slot as read out of the table.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [PORT_W-1:0] port;
  } slot_t;

  // Slot write request.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_t             data;
  } slot_wr_t;

  // Result of one item.
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  index;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] prefix;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/lprl_table.sv
// Route table storage: valid bits in flops, prefix/mask/port in a memory.
// One write port, one read port with registered read data. Uses lprl_pkg.
`default_nettype none

module lprl_table
  import lprl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire slot_wr_t          wr_i,
  input  wire logic [SLOT_W-1:0] rd_addr_i,
  output slot_t                  rd_data_o
);

  logic [ENTRIES-1:0] valid_q;
  logic [ADDR_W-1:0]  prefix_mem [ENTRIES];
  logic [ADDR_W-1:0]  mask_mem   [ENTRIES];
  logic [PORT_W-1:0]  port_mem   [ENTRIES];
  slot_t              rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= wr_i.data.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      prefix_mem[wr_i.addr] <= wr_i.data.prefix;
      mask_mem[wr_i.addr]   <= wr_i.data.mask;
      port_mem[wr_i.addr]   <= wr_i.data.port;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q.valid  <= valid_q[rd_addr_i];
    rd_q.prefix <= prefix_mem[rd_addr_i];
    rd_q.mask   <= mask_mem[rd_addr_i];
    rd_q.port   <= port_mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// File: hdl/lprl_engine.sv
// Scan sequencer with one shared masked-compare and mask-rank unit.
// Walks the table one slot a cycle and keeps the best match. Uses lprl_pkg.
`default_nettype none

module lprl_engine
  import lprl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_lookup_i,
  input  wire logic              start_write_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic              out_free_i,
  output logic                   busy_o,
  output logic                   done_o,
  output result_t                result_o,
  output logic [SLOT_W-1:0]      rd_addr_o,
  input  wire slot_t             rd_data_i
);

  eng_state_e        state_q, state_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] cmp_slot_q;
  logic              cmp_en_q;
  logic [ADDR_W-1:0] addr_q;
  logic              found_q, found_d;
  logic [SLOT_W-1:0] best_idx_q, best_idx_d;
  logic [ADDR_W-1:0] best_mask_q, best_mask_d;
  logic [ADDR_W-1:0] best_prefix_q, best_prefix_d;
  logic [PORT_W-1:0] best_port_q, best_port_d;
  logic              last_slot;
  logic              slot_match;
  logic              slot_better;
  logic [31:0]       best_idx_ext;

  assign last_slot = (cnt_q == SLOT_W'(ENTRIES - 1));

  // Shared compare unit: masked prefix equality, then rank by mask value.
  assign slot_match  = rd_data_i.valid &&
                       ((rd_data_i.prefix & rd_data_i.mask) == (addr_q & rd_data_i.mask));
  assign slot_better = cmp_en_q && slot_match && (!found_q || (rd_data_i.mask > best_mask_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_lookup_i) begin
          state_d = ST_SCAN;
        end else if (start_write_i) begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (last_slot) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d         = cnt_q;
    found_d       = found_q;
    best_idx_d    = best_idx_q;
    best_mask_d   = best_mask_q;
    best_prefix_d = best_prefix_q;
    best_port_d   = best_port_q;
    busy_o        = 1'b1;
    done_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        cnt_d  = '0;
        // clear the best match so a write or a miss reports all zero
        if (start_lookup_i || start_write_i) begin
          found_d       = 1'b0;
          best_idx_d    = '0;
          best_mask_d   = '0;
          best_prefix_d = '0;
          best_port_d   = '0;
        end
      end
      ST_SCAN: cnt_d = cnt_q + SLOT_W'(1);
      ST_TAIL: ;
      ST_DONE: done_o = 1'b1;
      default: ;
    endcase
    if (slot_better) begin
      found_d       = 1'b1;
      best_idx_d    = cmp_slot_q;
      best_mask_d   = rd_data_i.mask;
      best_prefix_d = rd_data_i.prefix;
      best_port_d   = rd_data_i.port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      cmp_en_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      cmp_en_q <= (state_q == ST_SCAN);
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_slot_q    <= cnt_q;
    best_idx_q    <= best_idx_d;
    best_mask_q   <= best_mask_d;
    best_prefix_q <= best_prefix_d;
    best_port_q   <= best_port_d;
    if (start_lookup_i && (state_q == ST_IDLE)) begin
      addr_q <= addr_i;
    end
  end

  assign rd_addr_o     = cnt_q;
  assign best_idx_ext  = 32'(best_idx_q);
  assign result_o.hit    = found_q;
  assign result_o.index  = best_idx_ext[IDX_W-1:0];
  assign result_o.port   = best_port_q;
  assign result_o.prefix = best_prefix_q;

endmodule

`default_nettype wire

// File: hdl/longest_prefix_route_lookup_top.sv
// Longest-prefix route lookup over an IPv4 routing table.
//
// Input channel (in_valid_i / in_stall_o) carries one word per item. A word
// with op_i = 0 writes slot entry_index_i (ignored when beyond the table); a
// word with op_i = 1 looks up lookup_addr_i. Output channel (out_valid_o /
// out_stall_i) returns one word per item: hit, slot, port and prefix of the
// valid route with the largest mask whose masked prefix equals the masked
// address, lowest slot on ties, all zero on a miss or a write.
//
// A lookup scans the table one slot a cycle through a single compare unit
// fed by the table's registered read port; the engine registers the best
// match, and the word then passes to the output register. A write sends
// an all-zero word. The block holds in_stall_o high while it works on an item.
//
// Reset clears all valid bits at once, so the table starts empty with no
// clearing pass. When the receiver stalls, the output word holds in its
// register; one further item may be accepted and processed, then it waits
// in the engine until the output register frees up.
// Depends on lprl_pkg, lprl_table and lprl_engine.
`default_nettype none

module longest_prefix_route_lookup_top
  import lprl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              op_i,
  input  wire logic [IDX_W-1:0]  entry_index_i,
  input  wire logic              entry_valid_i,
  input  wire logic [ADDR_W-1:0] entry_prefix_i,
  input  wire logic [ADDR_W-1:0] entry_mask_i,
  input  wire logic [PORT_W-1:0] entry_port_i,
  input  wire logic [ADDR_W-1:0] lookup_addr_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   hit_o,
  output logic [IDX_W-1:0]       match_index_o,
  output logic [PORT_W-1:0]      match_port_o,
  output logic [ADDR_W-1:0]      match_prefix_o
);

  logic              in_accept;
  logic              busy;
  logic              done;
  logic              out_free;
  logic              out_load;
  logic [31:0]       idx_ext;
  slot_wr_t          slot_wr;
  slot_t             rd_data;
  logic [SLOT_W-1:0] rd_addr;
  result_t           eng_result;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign idx_ext    = 32'(entry_index_i);

  always_comb begin
    slot_wr.en          = in_accept && (op_i == OP_WRITE) && (idx_ext < 32'(ENTRIES));
    slot_wr.addr        = idx_ext[SLOT_W-1:0];
    slot_wr.data.valid  = entry_valid_i;
    slot_wr.data.prefix = entry_prefix_i;
    slot_wr.data.mask   = entry_mask_i;
    slot_wr.data.port   = entry_port_i;
  end

  lprl_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (slot_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lprl_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_lookup_i (in_accept && (op_i == OP_LOOKUP)),
    .start_write_i  (in_accept && (op_i == OP_WRITE)),
    .addr_i         (lookup_addr_i),
    .out_free_i     (out_free),
    .busy_o         (busy),
    .done_o         (done),
    .result_o       (eng_result),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data)
  );

  // Output register: load a finished word whenever the slot is empty or drains.
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = done && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= eng_result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_q.hit;
  assign match_index_o  = out_q.index;
  assign match_port_o   = out_q.port;
  assign match_prefix_o = out_q.prefix;

endmodule

`default_nettype wire

// File: hdl/lprl_checker.sv
// Port-level checks for the route lookup top level, bound to it below.
// Sees only the top-level ports; uses lprl_pkg for widths.
`default_nettype none

module lprl_checker
  import lprl_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              hit_o,
  input wire logic [IDX_W-1:0]  match_index_o,
  input wire logic [PORT_W-1:0] match_port_o,
  input wire logic [ADDR_W-1:0] match_prefix_o
);

  // an accepted word keeps the input closed for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // a miss or a write reports all-zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |->
      (match_index_o == '0) && (match_port_o == '0) && (match_prefix_o == '0))
    else $error("nonzero fields on a miss");

  // a fresh output word only follows a cycle in which the block was busy
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without work in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      out_valid_o && $stable(hit_o) && $stable(match_index_o) &&
      $stable(match_port_o) && $stable(match_prefix_o))
    else $error("stalled output word changed");

endmodule

bind longest_prefix_route_lookup_top lprl_checker u_lprl_checker (.*);

`default_nettype wire

// File: dv/route_lookup_checker.sv
// Checker for the longest-prefix route lookup block: keeps its own route table,
// predicts the result word of every accepted input word and compares it in order.
// Depends on lprl_pkg for widths, table size, op codes and the result struct.
module route_lookup_checker
  import lprl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              op_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic              entry_valid_i,
  input  logic [ADDR_W-1:0] entry_prefix_i,
  input  logic [ADDR_W-1:0] entry_mask_i,
  input  logic [PORT_W-1:0] entry_port_i,
  input  logic [ADDR_W-1:0] lookup_addr_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              hit_i,
  input  logic [IDX_W-1:0]  match_index_i,
  input  logic [PORT_W-1:0] match_port_i,
  input  logic [ADDR_W-1:0] match_prefix_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic              route_valid  [ENTRIES];
  logic [ADDR_W-1:0] route_prefix [ENTRIES];
  logic [ADDR_W-1:0] route_mask   [ENTRIES];
  logic [PORT_W-1:0] route_port   [ENTRIES];
  result_t           expected_routes [$];
  int                mismatches = 0;

  assign fail_count_o = mismatches;

  // Largest numeric mask wins; a strict compare keeps the lowest slot on ties.
  function automatic result_t longest_match(input logic [ADDR_W-1:0] addr);
    result_t           best;
    logic [ADDR_W-1:0] best_mask;
    logic              found;
    best      = '0;
    best_mask = '0;
    found     = 1'b0;
    for (int s = 0; s < ENTRIES; s++) begin
      if (route_valid[s] && ((route_prefix[s] & route_mask[s]) == (addr & route_mask[s]))
          && (!found || route_mask[s] > best_mask)) begin
        found       = 1'b1;
        best_mask   = route_mask[s];
        best.hit    = 1'b1;
        best.index  = IDX_W'(s);
        best.port   = route_port[s];
        best.prefix = route_prefix[s];
      end
    end
    return best;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      for (int s = 0; s < ENTRIES; s++) route_valid[s] = 1'b0;
      expected_routes.delete();
      pending_o <= 0;
    end else begin
      // Retire the output word first: it never belongs to a word taken at this edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_routes.size() == 0) begin
          $display("%0t: unexpected word: hit=%0b index=%0d port=%0d prefix=%h",
                   $time, hit_i, match_index_i, match_port_i, match_prefix_i);
          mismatches++;
        end else begin
          want = expected_routes.pop_front();
          if (hit_i !== want.hit || match_index_i !== want.index ||
              match_port_i !== want.port || match_prefix_i !== want.prefix) begin
            $display("%0t: route mismatch: expected hit=%0b index=%0d port=%0d prefix=%h",
                     $time, want.hit, want.index, want.port, want.prefix);
            $display("%0t:                 actual   hit=%0b index=%0d port=%0d prefix=%h",
                     $time, hit_i, match_index_i, match_port_i, match_prefix_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_LOOKUP) begin
          expected_routes.push_back(longest_match(lookup_addr_i));
        end else begin
          // Prefix, mask and port are stored even when the slot is cleared.
          if (entry_index_i < ENTRIES) begin
            route_valid[entry_index_i]  = entry_valid_i;
            route_prefix[entry_index_i] = entry_prefix_i;
            route_mask[entry_index_i]   = entry_mask_i;
            route_port[entry_index_i]   = entry_port_i;
          end
          expected_routes.push_back('0);
        end
      end
      pending_o <= expected_routes.size();
    end
  end

endmodule

// File: dv/longest_prefix_route_lookup_top_tb.sv
// Testbench top for longest_prefix_route_lookup_top: clock, reset, route writes and
// lookups with random gaps and output stalls, and the final verdict.
// Depends on lprl_pkg, the block and route_lookup_checker.
module longest_prefix_route_lookup_top_tb
  import lprl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1225;
  localparam int CALM_AFTER   = 1100;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic              op            = OP_WRITE;
  logic [IDX_W-1:0]  entry_index   = '0;
  logic              entry_valid   = 1'b0;
  logic [ADDR_W-1:0] entry_prefix  = '0;
  logic [ADDR_W-1:0] entry_mask    = '0;
  logic [PORT_W-1:0] entry_port    = '0;
  logic [ADDR_W-1:0] lookup_addr   = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic              hit;
  logic [IDX_W-1:0]  match_index;
  logic [PORT_W-1:0] match_port;
  logic [ADDR_W-1:0] match_prefix;
  int                fail_count;
  int                pending;
  int                words_sent    = 0;
  logic              calm          = 1'b0;
  logic [ADDR_W-1:0] bases [4];

  always #5 clk = ~clk;

  longest_prefix_route_lookup_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .entry_index_i  (entry_index),
    .entry_valid_i  (entry_valid),
    .entry_prefix_i (entry_prefix),
    .entry_mask_i   (entry_mask),
    .entry_port_i   (entry_port),
    .lookup_addr_i  (lookup_addr),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .hit_o          (hit),
    .match_index_o  (match_index),
    .match_port_o   (match_port),
    .match_prefix_o (match_prefix)
  );

  route_lookup_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .op_i           (op),
    .entry_index_i  (entry_index),
    .entry_valid_i  (entry_valid),
    .entry_prefix_i (entry_prefix),
    .entry_mask_i   (entry_mask),
    .entry_port_i   (entry_port),
    .lookup_addr_i  (lookup_addr),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .hit_i          (hit),
    .match_index_i  (match_index),
    .match_port_i   (match_port),
    .match_prefix_i (match_prefix),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
    return (len == 0) ? '0 : ~32'h0 << (32 - len);
  endfunction

  function automatic int random_len();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 8;
      2:       return 16;
      3:       return 24;
      4:       return 32;
      default: return $urandom_range(1, 31);
    endcase
  endfunction

  // Called at the edge that took the previous word; returns at the edge that takes this one.
  task automatic send_word(input logic op_v, input logic [IDX_W-1:0] idx, input logic active,
                           input logic [ADDR_W-1:0] pfx, input logic [ADDR_W-1:0] msk,
                           input logic [PORT_W-1:0] prt, input logic [ADDR_W-1:0] addr);
    if (!calm && (words_sent / 64) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    op           <= op_v;
    entry_index  <= idx;
    entry_valid  <= active;
    entry_prefix <= pfx;
    entry_mask   <= msk;
    entry_port   <= prt;
    lookup_addr  <= addr;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    calm = (words_sent >= CALM_AFTER);
  endtask

  task automatic write_route(input logic [IDX_W-1:0] idx, input logic active,
                             input logic [ADDR_W-1:0] pfx, input logic [ADDR_W-1:0] msk,
                             input logic [PORT_W-1:0] prt);
    send_word(OP_WRITE, idx, active, pfx, msk, prt, $urandom());
  endtask

  task automatic look_up(input logic [ADDR_W-1:0] addr);
    send_word(OP_LOOKUP, IDX_W'($urandom()), 1'($urandom()), $urandom(), $urandom(),
              PORT_W'($urandom()), addr);
  endtask

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Output side: stall in random bursts, none once the run calms down.
  initial begin
    @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) out_stall <= 1'b0;
      else out_stall <= 1'b1;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  end

  initial begin
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] p;
    logic [ADDR_W-1:0] a;
    int                k;
    bases[0] = $urandom();
    bases[1] = {bases[0][31:16], 16'($urandom())};
    bases[2] = {bases[0][31:8], 8'($urandom())};
    bases[3] = $urandom();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every slot first so no lookup ever reads an unwritten slot.
    write_route(0, 1'b1, 32'h0A00_0000, prefix_mask(8), 4'd1);
    write_route(1, 1'b1, 32'h0A01_0000, prefix_mask(16), 4'd2);
    write_route(2, 1'b1, 32'h0A01_0200, prefix_mask(24), 4'd3);
    write_route(3, 1'b1, 32'h0A01_0277, prefix_mask(24), 4'd4);
    write_route(4, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    write_route(5, 1'b0, 32'h0A01_0203, 32'hFFFF_FFFF, 4'd5);
    write_route(6, 1'b1, 32'h0012_0034, 32'h00FF_00FF, 4'd6);
    for (int s = 7; s < ENTRIES - 1; s++) write_route(IDX_W'(s), 1'b0, '0, '0, '0);
    write_route(IDX_W'(ENTRIES - 1), 1'b1, 32'h0102_0304, '0, 4'd9);

    look_up(32'h0A01_0203);   // equal /24 masks, lower slot wins over the /8 and /16
    look_up(32'h0A01_FFFF);
    look_up(32'hFFFF_FFFF);
    look_up(32'h0000_0000);   // only the default route matches
    look_up(32'h5512_5534);   // non-contiguous mask beats the default route
    write_route(IDX_W'(ENTRIES - 1), 1'b0, 32'h0102_0304, '0, 4'd9);
    look_up(32'h0000_0000);   // miss once the default route is gone
    look_up(32'h0B00_0000);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) begin
        // Hold the input until the block has handed back every word.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      k = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 35) begin
        m = ($urandom_range(0, 7) == 0) ? $urandom() : prefix_mask(random_len());
        p = (bases[k] & m) | ($urandom() & ~m);
        write_route(IDX_W'($urandom_range(0, ENTRIES - 1)), $urandom_range(0, 9) != 0,
                    p, m, PORT_W'($urandom()));
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          a = $urandom();
        end else begin
          m = prefix_mask(random_len());
          a = (bases[k] & m) | ($urandom() & ~m);
        end
        look_up(a);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/lprl_pkg.sv
hdl/lprl_table.sv
hdl/lprl_engine.sv
hdl/longest_prefix_route_lookup_top.sv
hdl/lprl_checker.sv
dv/route_lookup_checker.sv
dv/longest_prefix_route_lookup_top_tb.sv
